### hw/rtl/nsrb_pkg.sv
`default_nettype none
package nsrb_pkg;

  // Request and reply items
  typedef struct packed {
    logic [7:0]  req_byte;
    logic        req_last;
    logic [30:0] now_seconds;
    logic [19:0] now_micros;
  } req_t;

  typedef struct packed {
    logic [7:0] reply_byte;
    logic       reply_last;
  } reply_t;

  // 64-bit NTP timestamp, seconds then fraction
  typedef struct packed {
    logic [31:0] secs;
    logic [31:0] frac;
  } stamp_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_DRIFT_ADJUST    = 2'd0,
    CFG_CLOCK_PRECISION = 2'd1,
    CFG_ROOT_DISPERSION = 2'd2
  } cfg_reg_t;

  // Top-level sequencer
  typedef enum logic [1:0] {
    ST_RX,
    ST_CALC,
    ST_TX
  } top_state_t;

  // Timestamp unit sequencer
  typedef enum logic [1:0] {
    TS_IDLE,
    TS_NORM,
    TS_DIV
  } ts_state_t;

  localparam logic [31:0] NTP_EPOCH_OFFSET = 32'd2208988800;
  localparam logic [19:0] USEC_PER_SEC     = 20'd1000000;
  localparam logic [4:0]  FRAC_LAST_BIT    = 5'd31;

  localparam logic [5:0]  COUNT_SAT        = 6'd49;
  localparam logic [5:0]  LAST_REQ_POS     = 6'd47;
  localparam logic [5:0]  ORIG_FIRST_POS   = 6'd40;
  localparam logic [5:0]  ORIG_END_POS     = 6'd48;
  localparam logic [5:0]  LAST_REPLY_IDX   = 6'd47;

  // Fixed reply header bytes
  localparam logic [7:0]  HDR_FLAGS        = 8'h1C;  // LI 0, version 3, mode 4
  localparam logic [7:0]  HDR_STRATUM      = 8'd1;
  localparam logic [7:0]  HDR_POLL         = 8'd6;
  localparam logic [7:0]  REFID_G          = 8'd71;
  localparam logic [7:0]  REFID_P          = 8'd80;
  localparam logic [7:0]  REFID_S          = 8'd83;

endpackage
`default_nettype wire

### hw/rtl/nsrb_ts_unit.sv
`default_nettype none
// Timestamp unit: folds the drift into the microsecond sample, normalizes
// it to 0..999999 one second step a cycle, then forms the 32-bit fraction
// by bit-serial long division by one million, one quotient bit a cycle.
module nsrb_ts_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [30:0]        now_seconds,
  input  wire logic [19:0]        now_micros,
  input  wire logic [20:0]        drift_adjust_us,
  output logic                    done,
  output nsrb_pkg::stamp_t        result
);

  nsrb_pkg::ts_state_t state, state_next;

  logic signed [21:0] t;
  logic        [31:0] secs;
  logic        [19:0] rem;
  logic        [31:0] frac;
  logic        [4:0]  cnt;

  logic        t_neg;
  logic        t_big;
  logic [20:0] rem2;
  logic        ge;

  assign t_neg = t[21];
  assign t_big = !t[21] && (t[20:0] >= {1'b0, nsrb_pkg::USEC_PER_SEC});
  assign rem2  = {rem, 1'b0};
  assign ge    = rem2 >= {1'b0, nsrb_pkg::USEC_PER_SEC};

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      nsrb_pkg::TS_IDLE: begin
        if (start) state_next = nsrb_pkg::TS_NORM;
      end
      nsrb_pkg::TS_NORM: begin
        if (!t_neg && !t_big) state_next = nsrb_pkg::TS_DIV;
      end
      nsrb_pkg::TS_DIV: begin
        if (cnt == nsrb_pkg::FRAC_LAST_BIT) state_next = nsrb_pkg::TS_IDLE;
      end
      default: state_next = nsrb_pkg::TS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nsrb_pkg::TS_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == nsrb_pkg::TS_DIV) && (cnt == nsrb_pkg::FRAC_LAST_BIT);
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      nsrb_pkg::TS_IDLE: begin
        if (start) begin
          t    <= $signed({2'b00, now_micros}) +
                  $signed({drift_adjust_us[20], drift_adjust_us});
          secs <= {1'b0, now_seconds} + nsrb_pkg::NTP_EPOCH_OFFSET;
        end
      end
      nsrb_pkg::TS_NORM: begin
        // borrow or carry one second per cycle; seconds wrap mod 2^32
        if (t_neg) begin
          t    <= t + $signed({2'b00, nsrb_pkg::USEC_PER_SEC});
          secs <= secs - 32'd1;
        end else if (t_big) begin
          t    <= t - $signed({2'b00, nsrb_pkg::USEC_PER_SEC});
          secs <= secs + 32'd1;
        end else begin
          // r + 1; when it equals one million every quotient bit is 1,
          // which is the saturated fraction
          rem <= t[19:0] + 20'd1;
          cnt <= '0;
        end
      end
      nsrb_pkg::TS_DIV: begin
        rem  <= ge ? 20'(rem2 - {1'b0, nsrb_pkg::USEC_PER_SEC}) : rem2[19:0];
        frac <= {frac[30:0], ge};
        cnt  <= cnt + 5'd1;
      end
      default: ;
    endcase
  end

  assign result.secs = secs;
  assign result.frac = frac;

endmodule
`default_nettype wire

### hw/rtl/nsrb_reply_tx.sv
`default_nettype none
// Reply serializer: walks the 48 reply bytes through an output register.
module nsrb_reply_tx (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire nsrb_pkg::stamp_t   stamp,
  input  wire logic [7:0]         clock_precision,
  input  wire logic [31:0]        root_dispersion,
  input  wire logic [7:0][7:0]    orig,
  input  wire logic               reply_stall,
  output logic                    reply_valid,
  output nsrb_pkg::reply_t        reply,
  output logic                    done
);

  logic       active;
  logic [5:0] idx;
  logic       load;
  logic [7:0] next_byte;

  logic [7:0][7:0] stamp_bytes;
  logic [3:0][7:0] disp_bytes;

  assign stamp_bytes = stamp;
  assign disp_bytes  = root_dispersion;

  assign load = active && (!reply_valid || !reply_stall);
  assign done = load && (idx == nsrb_pkg::LAST_REPLY_IDX);

  // Reply byte select, big endian within each field
  always_comb begin
    next_byte = '0;
    case (idx[5:3])
      3'd0: begin
        case (idx[2:0])
          3'd0:    next_byte = nsrb_pkg::HDR_FLAGS;
          3'd1:    next_byte = nsrb_pkg::HDR_STRATUM;
          3'd2:    next_byte = nsrb_pkg::HDR_POLL;
          3'd3:    next_byte = clock_precision;
          default: next_byte = '0;  // root delay
        endcase
      end
      3'd1: begin
        if (!idx[2]) begin
          next_byte = disp_bytes[~idx[1:0]];
        end else begin
          case (idx[1:0])
            2'd0:    next_byte = nsrb_pkg::REFID_G;
            2'd1:    next_byte = nsrb_pkg::REFID_P;
            2'd2:    next_byte = nsrb_pkg::REFID_S;
            default: next_byte = '0;
          endcase
        end
      end
      3'd2, 3'd4, 3'd5: next_byte = stamp_bytes[~idx[2:0]];  // ref, rx, tx
      3'd3:             next_byte = orig[idx[2:0]];           // originate
      default:          next_byte = '0;
    endcase
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      idx         <= '0;
      reply_valid <= 1'b0;
    end else begin
      if (start) begin
        active <= 1'b1;
        idx    <= '0;
      end
      if (load) begin
        reply_valid <= 1'b1;
        idx         <= idx + 6'd1;
        if (idx == nsrb_pkg::LAST_REPLY_IDX) active <= 1'b0;
      end else if (reply_valid && !reply_stall) begin
        reply_valid <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      reply.reply_byte <= next_byte;
      reply.reply_last <= (idx == nsrb_pkg::LAST_REPLY_IDX);
    end
  end

endmodule
`default_nettype wire

### hw/rtl/ntp_server_reply_builder.sv
// Request bytes: one per cycle while no reply is being built.
// Reply: the first byte follows the last request byte after normalization and
// the bit-serial fraction division, then one byte per cycle while reply_stall
// is low, 48 bytes in all; requests stall from the last byte until byte 47 loads.
// Synchronous active-high reset clears control, count and config registers;
// the originate store is not reset.
`default_nettype none
module ntp_server_reply_builder (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire nsrb_pkg::req_t    req,
  output logic                   reply_valid,
  input  wire logic              reply_stall,
  output nsrb_pkg::reply_t       reply,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [31:0]       cfg_data
);

  nsrb_pkg::top_state_t state, state_next;

  logic [20:0] drift_adjust_us;
  logic [7:0]  clock_precision;
  logic [31:0] root_dispersion;

  logic [5:0]      byte_count;
  logic [7:0][7:0] orig_store;

  logic             req_acc;
  logic             ts_start;
  logic             ts_done;
  nsrb_pkg::stamp_t stamp;
  logic             tx_done;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != nsrb_pkg::ST_RX);
  assign req_acc   = req_valid && !req_stall;
  assign ts_start  = req_acc && req.req_last && (byte_count == nsrb_pkg::LAST_REQ_POS);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      drift_adjust_us <= '0;
      clock_precision <= '0;
      root_dispersion <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        nsrb_pkg::CFG_DRIFT_ADJUST:    drift_adjust_us <= cfg_data[20:0];
        nsrb_pkg::CFG_CLOCK_PRECISION: clock_precision <= cfg_data[7:0];
        nsrb_pkg::CFG_ROOT_DISPERSION: root_dispersion <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request length count, saturating
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (req_acc) begin
      if (req.req_last) byte_count <= '0;
      else if (byte_count < nsrb_pkg::COUNT_SAT) byte_count <= byte_count + 6'd1;
    end
  end

  // Keep the client's transmit stamp, request bytes 40 to 47
  always_ff @(posedge clk) begin
    if (req_acc && byte_count >= nsrb_pkg::ORIG_FIRST_POS &&
        byte_count < nsrb_pkg::ORIG_END_POS) begin
      orig_store[byte_count[2:0]] <= req.req_byte;
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      nsrb_pkg::ST_RX:   if (ts_start) state_next = nsrb_pkg::ST_CALC;
      nsrb_pkg::ST_CALC: if (ts_done)  state_next = nsrb_pkg::ST_TX;
      nsrb_pkg::ST_TX:   if (tx_done)  state_next = nsrb_pkg::ST_RX;
      default:           state_next = nsrb_pkg::ST_RX;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= nsrb_pkg::ST_RX;
    else     state <= state_next;
  end

  nsrb_ts_unit u_ts (
    .clk             (clk),
    .rst             (rst),
    .start           (ts_start),
    .now_seconds     (req.now_seconds),
    .now_micros      (req.now_micros),
    .drift_adjust_us (drift_adjust_us),
    .done            (ts_done),
    .result          (stamp)
  );

  nsrb_reply_tx u_tx (
    .clk             (clk),
    .rst             (rst),
    .start           (ts_done),
    .stamp           (stamp),
    .clock_precision (clock_precision),
    .root_dispersion (root_dispersion),
    .orig            (orig_store),
    .reply_stall     (reply_stall),
    .reply_valid     (reply_valid),
    .reply           (reply),
    .done            (tx_done)
  );

endmodule
`default_nettype wire

### hw/rtl/nsrb_checker.sv
`default_nettype none
module nsrb_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              req_stall,
  input wire logic              reply_valid,
  input wire logic              reply_stall,
  input wire nsrb_pkg::reply_t  reply
);

  // stalled reply holds
  assert property (@(posedge clk) disable iff (rst)
    reply_valid && reply_stall |=> reply_valid && $stable(reply))
    else $error("stalled reply changed");

  // no reply right out of reset
  assert property (@(posedge clk)
    rst |=> !reply_valid)
    else $error("reply valid after reset");

  // requests held off while a reply is mid-stream
  assert property (@(posedge clk) disable iff (rst)
    reply_valid && !reply.reply_last |-> req_stall)
    else $error("request taken during reply");

  // a finished reply is not followed at once by another byte
  assert property (@(posedge clk) disable iff (rst)
    reply_valid && !reply_stall && reply.reply_last |=> !reply_valid)
    else $error("reply byte after end of reply");

endmodule

bind ntp_server_reply_builder nsrb_checker u_nsrb_checker (.*);
`default_nettype wire
